/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define BTS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define BTS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  `BTS_ASSERT(label, clk, rstn, (ante) |-> (cons), msg)

`endif

/* rtl/core/bts_pkg.sv */
package bts_pkg;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int GEOM_W   = 11;
  localparam int MIN_GEOM = 3;
  localparam int RESET_GEOM = 1024;

  localparam logic [1:0] REG_PASS   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic pixel_in;
    logic flush;
  } bts_in_t;

  typedef struct packed {
    logic pixel_out;
    logic removed;
    logic frame_last;
    logic any_removed;
  } bts_out_t;

  // control from the register block to the datapath
  typedef struct packed {
    logic pass_sel;
    logic restart;
  } bts_ctl_t;

endpackage

/* rtl/core/bts_ram.sv */
module bts_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/bts_cfg.sv */
module bts_cfg
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ADDR_W-1:0]                  cfg_paddr,
  input  logic [DATA_W-1:0]                  cfg_pwdata,
  output logic [DATA_W-1:0]                  cfg_prdata,
  output logic                               cfg_pready,
  output bts_ctl_t                           ctl,
  output logic [$clog2(MAX_WIDTH+1)-1:0]     eff_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]    eff_h
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  function automatic int unsigned clamp_geom(input logic [GEOM_W-1:0] v,
                                             input int unsigned lim);
    int unsigned x;
    x = 32'(v);
    if (x < MIN_GEOM) return MIN_GEOM;
    if (x > lim) return lim;
    return x;
  endfunction

  logic              pass_r, pass_nxt;
  logic [GEOM_W-1:0] fw_r, fw_nxt;
  logic [GEOM_W-1:0] fh_r, fh_nxt;
  logic [WW-1:0]     eff_w_r, eff_w_nxt;
  logic [HW-1:0]     eff_h_r, eff_h_nxt;
  logic              wr;
  logic [1:0]        idx;

  assign wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx = cfg_paddr[3:2];

  always_comb begin
    pass_nxt  = pass_r;
    fw_nxt    = fw_r;
    fh_nxt    = fh_r;
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (wr) begin
      unique case (idx)
        REG_PASS: begin
          pass_nxt = cfg_pwdata[0];
        end
        REG_WIDTH: begin
          fw_nxt    = cfg_pwdata[GEOM_W-1:0];
          eff_w_nxt = WW'(clamp_geom(cfg_pwdata[GEOM_W-1:0], MAX_WIDTH));
        end
        REG_HEIGHT: begin
          fh_nxt    = cfg_pwdata[GEOM_W-1:0];
          eff_h_nxt = HW'(clamp_geom(cfg_pwdata[GEOM_W-1:0], MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r  <= 1'b0;
      fw_r    <= GEOM_W'(RESET_GEOM);
      fh_r    <= GEOM_W'(RESET_GEOM);
      eff_w_r <= WW'(clamp_geom(GEOM_W'(RESET_GEOM), MAX_WIDTH));
      eff_h_r <= HW'(clamp_geom(GEOM_W'(RESET_GEOM), MAX_HEIGHT));
    end else begin
      pass_r  <= pass_nxt;
      fw_r    <= fw_nxt;
      fh_r    <= fh_nxt;
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_PASS:   cfg_prdata = DATA_W'(pass_r);
      REG_WIDTH:  cfg_prdata = DATA_W'(fw_r);
      REG_HEIGHT: cfg_prdata = DATA_W'(fh_r);
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg_pready   = 1'b1;
  assign ctl.pass_sel = pass_r;
  assign ctl.restart  = wr && ((idx == REG_WIDTH) || (idx == REG_HEIGHT));
  assign eff_w        = eff_w_r;
  assign eff_h        = eff_h_r;

endmodule

/* rtl/core/binary_thinning_subpass.sv */
// One Zhang-Suen thinning sub-pass over a binary raster stream.
// Input channel (in_valid/in_ready/in_data): one pixel per request in raster
// order; after the last pixel of a frame, frame_width+1 drain requests
// (flush=1, or any request once all pixels are in) push out the tail.
// A flush request that arrives while pixels are still due is swallowed.
// Output channel (out_valid/out_ready/out_data): the result for pixel k is
// triggered by request k+frame_width+1 and, once that request is taken, shows
// on out_valid after the stage-B register and the output register. frame_last
// marks the frame's final result and carries any_removed.
// Throughput: one request per clock unless stalled. A single-port-read line
// memory of MAX_WIDTH x 2 bits (the two rows above the current one) is read
// once and written once per request, feeding a 3x3 window register.
// Stall: while a result waits in the output register and out_ready is low,
// in_ready is low and the whole pipe holds.
// Reset: counters, window and valid flags clear; pass_select=0, width and
// height 1024. The line memory is not cleared: rows it returns before they
// are written feed only border pixels. Writing width or height restarts the
// frame; configure only while idle.
module binary_thinning_subpass
  import bts_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bts_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bts_out_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);   // width value
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // height value
  localparam int RW = $clog2(MAX_HEIGHT + 2);  // row index, runs to height+1

  bts_ctl_t      ctl;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  bts_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .ctl         (ctl),
    .eff_w       (eff_w),
    .eff_h       (eff_h)
  );

  // ---------------------------------------------------------------------
  // Stage A: raster position of the incoming request
  // ---------------------------------------------------------------------
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] h_ext;
  logic          move, accept, pix_phase, enter;
  logic          last_pos, emit_pos, int_pos, col_wrap;

  // whole pipe advances whenever the output register can take a result
  assign move     = !out_valid || out_ready;
  assign in_ready = move;
  assign accept   = in_valid && in_ready;

  assign h_ext     = RW'(eff_h);
  assign pix_phase = row_r < h_ext;
  assign enter     = accept && !(pix_phase && in_data.flush);
  assign col_wrap  = (WW'(col_r) + WW'(1)) == eff_w;

  // final drain request: first column of row height+1
  assign last_pos = (row_r == (h_ext + RW'(1))) && (col_r == '0);
  // results start at request width+1
  assign emit_pos = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
  // window center is (row-1, col-1); interior test on that position
  assign int_pos  = (col_r >= CW'(2)) && (row_r >= RW'(2)) &&
                    (row_r <= (h_ext - RW'(1)));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (ctl.restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (enter) begin
      if (last_pos) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (col_wrap) begin
        row_nxt = row_r + RW'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: line memory data back, window shift, judgment
  // ---------------------------------------------------------------------
  logic          b_valid_r, b_valid_nxt;
  logic          b_pix_r, b_emit_r, b_int_r, b_last_r;
  logic [CW-1:0] b_col_r;
  logic [1:0]    lm_rdata;  // [1] two rows up, [0] one row up
  logic [1:0]    lm_wdata;
  logic          lm_we;

  assign b_valid_nxt = ctl.restart ? 1'b0 : (move ? enter : b_valid_r);

  // Consecutive requests always hit different columns (width >= 3), except
  // across the frame seam, where the read row is never used by an interior
  // pixel. No forwarding is needed.
  assign lm_we    = move && b_valid_r;
  assign lm_wdata = {lm_rdata[0], b_pix_r};

  bts_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (lm_we),
    .waddr (b_col_r),
    .wdata (lm_wdata),
    .re    (enter),
    .raddr (col_r),
    .rdata (lm_rdata)
  );

  // window columns, bit [2] top, [1] middle, [0] bottom
  logic [2:0] win_l_r, win_m_r, win_r;
  logic       p2, p3, p4, p5, p6, p7, p8, p9, center;
  logic [3:0] trans, cnt;
  logic       m1, m2, rem;
  logic       seen_r, seen_nxt;

  assign win_r = {lm_rdata, b_pix_r};

  always_comb begin
    p2     = win_m_r[2];
    p3     = win_r[2];
    p4     = win_r[1];
    p5     = win_r[0];
    p6     = win_m_r[0];
    p7     = win_l_r[0];
    p8     = win_l_r[1];
    p9     = win_l_r[2];
    center = win_m_r[1];
    trans  = 4'(!p2 && p3) + 4'(!p3 && p4) + 4'(!p4 && p5) + 4'(!p5 && p6) +
             4'(!p6 && p7) + 4'(!p7 && p8) + 4'(!p8 && p9) + 4'(!p9 && p2);
    cnt    = 4'(p2) + 4'(p3) + 4'(p4) + 4'(p5) + 4'(p6) + 4'(p7) + 4'(p8) + 4'(p9);
    if (ctl.pass_sel) begin
      m1 = p2 & p4 & p8;
      m2 = p2 & p6 & p8;
    end else begin
      m1 = p2 & p4 & p6;
      m2 = p4 & p6 & p8;
    end
    rem = b_int_r && center && (trans == 4'd1) && (cnt >= 4'd2) && (cnt <= 4'd6) &&
          !m1 && !m2;
  end

  // frame removal flag, cleared by the frame's last result
  always_comb begin
    seen_nxt = seen_r;
    if (ctl.restart) begin
      seen_nxt = 1'b0;
    end else if (move && b_valid_r && b_emit_r) begin
      seen_nxt = b_last_r ? 1'b0 : (seen_r | rem);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic     o_valid_r, o_valid_nxt;
  bts_out_t o_data_r;

  assign o_valid_nxt = move ? (b_valid_r && b_emit_r) : o_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      b_valid_r <= 1'b0;
      win_l_r   <= '0;
      win_m_r   <= '0;
      seen_r    <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      b_valid_r <= b_valid_nxt;
      seen_r    <= seen_nxt;
      o_valid_r <= o_valid_nxt;
      if (move && b_valid_r) begin
        win_l_r <= win_m_r;
        win_m_r <= win_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (move && enter) begin
      b_pix_r  <= in_data.pixel_in & pix_phase;  // drain pixels read as 0
      b_col_r  <= col_r;
      b_emit_r <= emit_pos;
      b_int_r  <= int_pos;
      b_last_r <= last_pos;
    end
    if (move && b_valid_r && b_emit_r) begin
      o_data_r.pixel_out   <= center & !rem;
      o_data_r.removed     <= rem;
      o_data_r.frame_last  <= b_last_r;
      o_data_r.any_removed <= b_last_r & (seen_r | rem);
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

/* rtl/core/bts_checker.sv */
`include "assert_macros.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input bts_out_t out_data
);

  // stalled result stays put
  `BTS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped or changed while stalled")

  // a stalled result blocks the input side
  `BTS_ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready, "request taken while output stalled")

  `BTS_ASSERT_IMPL(a_any_on_last, clk, rst_n, out_valid && out_data.any_removed, out_data.frame_last, "any_removed outside frame end")

  `BTS_ASSERT_IMPL(a_removed_clear, clk, rst_n, out_valid && out_data.removed, !out_data.pixel_out, "removed pixel still set")

endmodule

bind binary_thinning_subpass bts_checker u_bts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/binary_thinning_subpass_tb.sv */
// Testbench for the thinning sub-pass block.
//
// A bit-level copy of the sub-pass lives in this module: a history of the
// pixels taken in, the frame counters and the register values. Every accepted
// request runs through judge_pixel(); when it yields a result, that result (or
// a typed-in expectation) is queued in pending_pixels and the output monitor
// compares it field by field with what the block emits, oldest first.
//
// Order of the run:
//   - reset geometry (1024 wide): a short stretch of row 0, abandoned by the
//     next geometry write
//   - a directed 3x3 table with typed-in expectations
//   - four traffic phases of random frames (no gaps, sender gaps, receiver
//     stalls, both), with random geometry incl. values that get clamped
//   - in the first phase also a mid-size frame with a long receiver hold-off
//     so the block backs up and drops in_ready
module binary_thinning_subpass_tb;
  import bts_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  // history depth of the prediction: two rows plus a few pixels
  localparam int HIST = 2 * MAX_W + 3;

  // one row of the directed table: request, and optionally the result it
  // triggers, typed in by hand
  typedef struct packed {
    bts_in_t  req;
    logic     typed;
    bts_out_t want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  bts_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bts_out_t          out_data;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  // predicted register values (raw, as written)
  logic              cfg_pass = 1'b0;
  logic [GEOM_W-1:0] cfg_w = GEOM_W'(RESET_GEOM);
  logic [GEOM_W-1:0] cfg_h = GEOM_W'(RESET_GEOM);

  // predicted datapath state
  bit hist [HIST];
  int in_idx = 0;
  int out_idx = 0;
  bit seen_removal = 1'b0;

  bts_out_t pending_pixels [$];
  bts_out_t oldest;
  int       errors = 0;

  // traffic shaping
  int send_idle = 0;
  int stall_pct = 0;
  bit calm = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // Directed 3x3 frames, pass 0. {pixel_in,flush} / typed / {pix,rem,last,any}.
  // Frame A:  1 1 0   center has ring 1,0,0,0,0,0,1,1: one 0->1 step,
  //           1 1 0   three set neighbors, both products zero -> removed.
  //           0 0 0
  // Frame B: all ones, center has eight neighbors set -> kept.
  dir_row_t dir_tab [27] = '{
    '{2'b10, 1'b0, 4'b0000},
    '{2'b10, 1'b0, 4'b0000},
    '{2'b11, 1'b0, 4'b0000},  // flush while pixels still due: swallowed
    '{2'b00, 1'b0, 4'b0000},
    '{2'b10, 1'b0, 4'b0000},
    '{2'b10, 1'b1, 4'b1000},  // first result: pixel 0
    '{2'b00, 1'b1, 4'b1000},
    '{2'b00, 1'b1, 4'b0000},
    '{2'b00, 1'b1, 4'b1000},
    '{2'b00, 1'b1, 4'b0100},  // center cleared
    '{2'b01, 1'b1, 4'b0000},
    '{2'b10, 1'b1, 4'b0000},  // plain pixel after the frame is in: drains
    '{2'b01, 1'b1, 4'b0000},
    '{2'b01, 1'b1, 4'b0011},  // frame end, a removal was seen
    '{2'b10, 1'b0, 4'b0000},
    '{2'b10, 1'b0, 4'b0000},
    '{2'b10, 1'b0, 4'b0000},
    '{2'b10, 1'b0, 4'b0000},
    '{2'b10, 1'b1, 4'b1000},
    '{2'b10, 1'b1, 4'b1000},
    '{2'b10, 1'b1, 4'b1000},
    '{2'b10, 1'b1, 4'b1000},
    '{2'b10, 1'b1, 4'b1000},  // center kept: too many neighbors
    '{2'b01, 1'b1, 4'b1000},
    '{2'b01, 1'b1, 4'b1000},
    '{2'b01, 1'b1, 4'b1000},
    '{2'b01, 1'b1, 4'b1010}   // frame end, nothing removed
  };

  binary_thinning_subpass #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // geometry registers are clamped to 3..top on use
  function automatic int clamp_geom(input logic [GEOM_W-1:0] v, input int top);
    if (v < MIN_GEOM) return MIN_GEOM;
    if (v > top) return top;
    return int'(v);
  endfunction

  // One accepted request through the sub-pass. Returns 1 with the result it
  // triggers, 0 when it only fills the history or is swallowed.
  function automatic bit judge_pixel(input bts_in_t d, output bts_out_t r);
    int       w;
    int       h;
    int       total;
    int       k;
    int       row;
    int       col;
    int       trans;
    int       cnt;
    bit [7:0] ring;  // ring[0] is north, then clockwise
    bit       center;
    bit       m1;
    bit       m2;
    bit       rem;
    w = clamp_geom(cfg_w, MAX_W);
    h = clamp_geom(cfg_h, MAX_H);
    total = w * h;
    r = '0;
    if (in_idx < total) begin
      if (d.flush) return 1'b0;  // early flush changes nothing
      hist[in_idx % HIST] = d.pixel_in;
    end
    if (in_idx < w + 1) begin
      in_idx++;
      return 1'b0;
    end
    k = out_idx;
    row = k / w;
    col = k % w;
    center = hist[k % HIST];
    rem = 1'b0;
    if (row >= 1 && row + 1 < h && col >= 1 && col + 1 < w) begin
      ring[0] = hist[(k - w) % HIST];
      ring[1] = hist[(k - w + 1) % HIST];
      ring[2] = hist[(k + 1) % HIST];
      ring[3] = hist[(k + w + 1) % HIST];
      ring[4] = hist[(k + w) % HIST];
      ring[5] = hist[(k + w - 1) % HIST];
      ring[6] = hist[(k - 1) % HIST];
      ring[7] = hist[(k - w - 1) % HIST];
      trans = 0;
      for (int i = 0; i < 8; i++) begin
        if (!ring[i] && ring[(i + 1) % 8]) trans++;
      end
      cnt = $countones(ring);
      if (!cfg_pass) begin
        m1 = ring[0] & ring[2] & ring[4];
        m2 = ring[2] & ring[4] & ring[6];
      end else begin
        m1 = ring[0] & ring[2] & ring[6];
        m2 = ring[0] & ring[4] & ring[6];
      end
      rem = center && trans == 1 && cnt >= 2 && cnt <= 6 && !m1 && !m2;
    end
    seen_removal |= rem;
    r.pixel_out = center & ~rem;
    r.removed = rem;
    r.frame_last = (k + 1 == total);
    r.any_removed = r.frame_last & seen_removal;
    if (r.frame_last) begin
      in_idx = 0;
      out_idx = 0;
      seen_removal = 1'b0;
    end else begin
      in_idx++;
      out_idx++;
    end
    return 1'b1;
  endfunction

  // Offer one request and hold it until taken; the prediction (or the typed
  // expectation) is queued at the accepting edge.
  task automatic push_req(input bts_in_t d, input bit typed, input bts_out_t want);
    bts_out_t r;
    while (!calm && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (judge_pixel(d, r))
      pending_pixels.insert(pending_pixels.size(), typed ? want : r);
  endtask

  // Stop offering, let every expected result arrive, then let the pipe run on
  // idle for requests that trigger no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, then access; lands at the edge with pready high.
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_PASS: cfg_pass = data[0];
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) cfg_w = data[GEOM_W-1:0];
        else cfg_h = data[GEOM_W-1:0];
        // geometry write drops the frame in progress
        in_idx = 0;
        out_idx = 0;
        seen_removal = 1'b0;
      end
      default: ;
    endcase
  endtask

  // One random frame. Unused upper register bits carry junk. Small frames
  // sometimes stop partway (abandoned by the next geometry write) or switch
  // pass in the middle. squeeze asks for a long receiver hold-off mid-frame.
  task automatic run_frame(input int w_val, input int h_val, input bit pass_val,
                           input bit squeeze, inout int fed);
    int          w;
    int          total;
    int          dens;
    int          mode;
    int          cut;
    logic [31:0] junk;
    settle();
    junk = $urandom();
    reg_write(REG_PASS, {junk[31:1], pass_val});
    junk = $urandom();
    reg_write(REG_WIDTH, {junk[31:GEOM_W], w_val[GEOM_W-1:0]});
    junk = $urandom();
    reg_write(REG_HEIGHT, {junk[31:GEOM_W], h_val[GEOM_W-1:0]});
    w = clamp_geom(w_val[GEOM_W-1:0], MAX_W);
    total = w * clamp_geom(h_val[GEOM_W-1:0], MAX_H);
    calm = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: dens = 15;
      1: dens = 85;
      default: dens = 50;
    endcase
    mode = (total > 200) ? 2 : $urandom_range(0, 9);
    cut = $urandom_range(1, total - 1);
    for (int i = 0; i < total; i++) begin
      if (mode == 0 && i == cut) return;
      if (mode == 1 && i == cut) begin
        settle();
        reg_write(REG_PASS, {$urandom_range(0, 1) ? 31'h7fffffff : 31'h0, ~cfg_pass});
      end
      if (squeeze && i == total / 2) hold_req <= 1'b1;
      // stray flush while pixels are due; the block drops it
      if ($urandom_range(0, 99) < 4)
        push_req('{pixel_in: 1'($urandom), flush: 1'b1}, 1'b0, '0);
      push_req('{pixel_in: ($urandom_range(0, 99) < dens), flush: 1'b0}, 1'b0, '0);
      fed++;
    end
    // drain: mostly flush, sometimes a plain pixel which acts the same
    for (int i = 0; i <= w; i++) begin
      push_req('{pixel_in: 1'($urandom), flush: ($urandom_range(0, 4) != 0)}, 1'b0, '0);
      fed++;
    end
  endtask

  // Output side: random ready, a counted hold-off on request, and the check
  // of every accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("result with nothing expected: %b", out_data);
        errors++;
      end else begin
        oldest = pending_pixels.pop_front();
        if (out_data.pixel_out !== oldest.pixel_out) begin
          $error("pixel_out: expected %0b, got %0b", oldest.pixel_out, out_data.pixel_out);
          errors++;
        end
        if (out_data.removed !== oldest.removed) begin
          $error("removed: expected %0b, got %0b", oldest.removed, out_data.removed);
          errors++;
        end
        if (out_data.frame_last !== oldest.frame_last) begin
          $error("frame_last: expected %0b, got %0b", oldest.frame_last,
                 out_data.frame_last);
          errors++;
        end
        if (out_data.any_removed !== oldest.any_removed) begin
          $error("any_removed: expected %0b, got %0b", oldest.any_removed,
                 out_data.any_removed);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int fed;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry is 1024 wide: 30 pixels only fill the history, no
    // result is due yet. The frame is then left unfinished.
    for (int i = 0; i < 30; i++)
      push_req('{pixel_in: 1'($urandom), flush: 1'b0}, 1'b0, '0);
    settle();

    reg_write(REG_PASS, '0);
    reg_write(REG_WIDTH, 32'd3);
    reg_write(REG_HEIGHT, 32'd3);
    foreach (dir_tab[i]) push_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 88; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 88; end
        default: begin send_idle = 31; stall_pct = 31; end
      endcase
      fed = 0;
      // widths/heights below 3 exercise the low clamp
      while (fed < 140)
        run_frame($urandom_range(0, 8), $urandom_range(0, 7), 1'($urandom), 1'b0, fed);
      if (phase == 0) begin
        // mid-size frame with the long receiver hold-off halfway through
        run_frame(30, 7, 1'b0, 1'b1, fed);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS binary_thinning_subpass");
    end else begin
      $display("FAIL binary_thinning_subpass");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #1000000;
    $display("FAIL binary_thinning_subpass");
    $finish;
  end

endmodule

/* binary_thinning_subpass.f */
+incdir+rtl/core
rtl/core/bts_pkg.sv
rtl/core/bts_ram.sv
rtl/core/bts_cfg.sv
rtl/core/binary_thinning_subpass.sv
rtl/core/bts_checker.sv
test/binary_thinning_subpass_tb.sv
